// ----- rtl/core/lec_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lec_pkg
// Shared types, codes and constants of the windowed log entry cache.
// ----------------------------------------------------------------------------
package lec_pkg;

   localparam int DEFAULT_CACHE_DEPTH = 1024;

   localparam logic [2:0] CMD_ADD       = 3'd0;
   localparam logic [2:0] CMD_GET       = 3'd1;
   localparam logic [2:0] CMD_TRUNCATE  = 3'd2;
   localparam logic [2:0] CMD_RESET     = 3'd3;
   localparam logic [2:0] CMD_EXISTS    = 3'd4;
   localparam logic [2:0] CMD_SET_REQ   = 3'd5;
   localparam logic [2:0] CMD_CLEAR_REQ = 3'd6;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_INTR  = 3'd1;
   localparam logic [2:0] ST_FULL  = 3'd2;
   localparam logic [2:0] ST_EMPTY = 3'd3;
   localparam logic [2:0] ST_SWAP  = 3'd4;
   localparam logic [2:0] ST_RANGE = 3'd5;

   localparam logic [1:0] CSR_MAX_BYTES = 2'd0;
   localparam logic [1:0] CSR_RETAIN    = 2'd1;
   localparam logic [1:0] CSR_RATIO     = 2'd2;
   localparam logic [1:0] CSR_ENABLE    = 2'd3;

   typedef struct packed {
      logic [2:0]  command;
      logic [47:0] log_index;
      logic [47:0] entry_term;
      logic [23:0] entry_length;
      logic        entry_outer;
      logic [15:0] entry_flag;
      logic [31:0] entry_checksum;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        hit;
      logic [47:0] hit_term;
      logic [23:0] hit_length;
      logic        hit_outer;
      logic [15:0] hit_flag;
      logic [31:0] hit_checksum;
      logic        wake_prefetcher;
   } rsp_type;

   typedef struct packed {
      logic [47:0] term;
      logic [23:0] length;
      logic        outer;
      logic [15:0] flag;
      logic [31:0] checksum;
   } entry_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_LATCH, DP_CLEAR, DP_RD_HEAD, DP_RD_TAIL, DP_RD_HIT, DP_CAP_HIT,
      DP_POP_FRONT, DP_POP_BACK, DP_WRITE, DP_SET_PEND, DP_CLR_PEND, DP_RESP
   } dp_op_type;

   typedef enum logic [2:0] {
      RK_PLAIN, RK_GET, RK_HIT, RK_EXISTS, RK_RESET
   } rsp_kind_type;

   typedef struct packed {
      dp_op_type    op;
      logic [2:0]   status;
      rsp_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] command;
      logic       intr;
      logic       in_win;
      logic       out_seq;
      logic       over;
      logic       cnt_nz;
      logic       gt_pend;
      logic       ring_full;
      logic       empty;
      logic       below;
      logic       beyond;
      logic       trim_range;
      logic       trim_hit;
      logic       trunc_en;
      logic       trunc_clear;
      logic       trunc_more;
      logic       out_busy;
   } dp_stat_type;

endpackage
`default_nettype wire

// ----- rtl/core/lec_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lec_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/lec_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lec_datapath
// Window registers, entry RAM, configuration registers and result register.
// ----------------------------------------------------------------------------
module lec_datapath
   import lec_pkg::*;
#(
   parameter int CACHE_DEPTH = DEFAULT_CACHE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req_data,
   input  wire logic        csr_valid,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire dp_cmd_type  cmd,
   output dp_stat_type      stat,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data
);

   localparam int SW = $clog2(CACHE_DEPTH);
   localparam int CW = $clog2(CACHE_DEPTH + 1);

   req_type     req_ff;
   logic [SW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [47:0] first_ff, first_in;
   logic [32:0] bytes_ff, bytes_in;
   logic [47:0] pend_ff, pend_in;
   logic        restart_ff, restart_in;
   logic [31:0] max_ff;
   logic [10:0] retain_ff;
   logic [7:0]  ratio_ff;
   logic        enable_ff;
   entry_type   cap_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   entry_type   rd_entry, wr_entry;
   logic [CW-1:0] offset;
   logic [CW:0]   slot_sum;
   logic [SW-1:0] slot;
   logic [48:0] idx_x, first_x, end_x;
   logic [40:0] ratio_prod;
   logic        ratio_ok;
   logic        ram_rd, ram_wr;

   assign idx_x   = {1'b0, req_ff.log_index};
   assign first_x = {1'b0, first_ff};
   assign end_x   = first_x + 49'(count_ff);

   always_comb begin
      case (cmd.op)
         DP_RD_TAIL: offset = count_ff - CW'(1);
         DP_RD_HIT:  offset = CW'(req_ff.log_index - first_ff);
         DP_WRITE:   offset = count_ff;
         default:    offset = '0;
      endcase
   end

   always_comb begin
      if (cmd.op == DP_WRITE && count_ff == '0) begin
         slot_sum = '0;
      end else begin
         slot_sum = (CW + 1)'(head_ff) + (CW + 1)'(offset);
      end
      if (slot_sum >= (CW + 1)'(CACHE_DEPTH)) begin
         slot = SW'(slot_sum - (CW + 1)'(CACHE_DEPTH));
      end else begin
         slot = SW'(slot_sum);
      end
   end

   assign ram_rd = (cmd.op == DP_RD_HEAD) || (cmd.op == DP_RD_TAIL) || (cmd.op == DP_RD_HIT);
   assign ram_wr = (cmd.op == DP_WRITE);

   always_comb begin
      wr_entry.term     = req_ff.entry_term;
      wr_entry.length   = req_ff.entry_length;
      wr_entry.outer    = req_ff.entry_outer;
      wr_entry.flag     = req_ff.entry_flag;
      wr_entry.checksum = req_ff.entry_checksum;
   end

   lec_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(CACHE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr),
      .wr_addr(slot),
      .wr_data(wr_entry),
      .rd_en  (ram_rd),
      .rd_addr(slot),
      .rd_data(rd_entry)
   );

   assign ratio_prod = 41'(bytes_ff) * 41'(ratio_ff);
   assign ratio_ok   = ratio_prod <= 41'(max_ff);

   always_comb begin
      stat.command     = req_ff.command;
      stat.intr        = !enable_ff || restart_ff;
      stat.in_win      = (idx_x >= first_x) && (idx_x < end_x);
      stat.out_seq     = (first_ff != '0) && ((idx_x < first_x) || (idx_x > end_x));
      stat.over        = (34'(bytes_ff) + 34'(req_ff.entry_length)) > 34'(max_ff);
      stat.cnt_nz      = count_ff != '0;
      stat.gt_pend     = req_ff.log_index > pend_ff;
      stat.ring_full   = count_ff == CW'(CACHE_DEPTH);
      stat.empty       = (max_ff == '0) || (first_ff == '0);
      stat.below       = idx_x < first_x;
      stat.beyond      = idx_x >= end_x;
      stat.trim_range  = 32'(count_ff) > 32'(retain_ff);
      stat.trim_hit    = (count_ff != '0) &&
                         (((first_x + 49'(retain_ff)) < idx_x) ||
                          (((first_x + 49'd1) < idx_x) &&
                           ({bytes_ff, 1'b0} > 34'(max_ff))));
      stat.trunc_en    = (max_ff != '0) && (count_ff != '0);
      stat.trunc_clear = idx_x <= first_x;
      stat.trunc_more  = (count_ff != '0) && (idx_x < end_x);
      stat.out_busy    = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      first_in   = first_ff;
      bytes_in   = bytes_ff;
      pend_in    = pend_ff;
      restart_in = restart_ff;
      rsp_in     = rsp_ff;
      case (cmd.op)
         DP_CLEAR: begin
            head_in  = '0;
            count_in = '0;
            first_in = '0;
            bytes_in = '0;
            if (cmd.kind == RK_RESET) begin
               restart_in = 1'b1;
            end
         end
         DP_POP_FRONT: begin
            bytes_in = bytes_ff - 33'(rd_entry.length);
            head_in  = (head_ff == SW'(CACHE_DEPTH - 1)) ? '0 : head_ff + SW'(1);
            count_in = count_ff - CW'(1);
            first_in = first_ff + 48'd1;
         end
         DP_POP_BACK: begin
            bytes_in = bytes_ff - 33'(rd_entry.length);
            count_in = count_ff - CW'(1);
         end
         DP_WRITE: begin
            if (count_ff == '0) begin
               first_in = req_ff.log_index;
               head_in  = '0;
            end
            count_in = count_ff + CW'(1);
            bytes_in = bytes_ff + 33'(req_ff.entry_length);
         end
         DP_SET_PEND: begin
            if (req_ff.log_index != '0) begin
               pend_in = req_ff.log_index;
            end
         end
         DP_CLR_PEND: begin
            pend_in = '0;
         end
         DP_RESP: begin
            rsp_in = '0;
            rsp_in.status = cmd.status;
            case (cmd.kind)
               RK_HIT: begin
                  rsp_in.hit          = 1'b1;
                  rsp_in.hit_term     = cap_ff.term;
                  rsp_in.hit_length   = cap_ff.length;
                  rsp_in.hit_outer    = cap_ff.outer;
                  rsp_in.hit_flag     = cap_ff.flag;
                  rsp_in.hit_checksum = cap_ff.checksum;
                  rsp_in.wake_prefetcher = ratio_ok;
                  restart_in = 1'b0;
               end
               RK_GET: begin
                  rsp_in.wake_prefetcher = ratio_ok || (cmd.status == ST_RANGE) ||
                                           (cmd.status == ST_SWAP);
                  restart_in = cmd.status == ST_SWAP;
               end
               RK_EXISTS: begin
                  rsp_in.hit = stat.in_win;
               end
               RK_RESET: begin
                  rsp_in.wake_prefetcher = 1'b1;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         first_ff     <= '0;
         bytes_ff     <= '0;
         pend_ff      <= '0;
         restart_ff   <= 1'b0;
         max_ff       <= '0;
         retain_ff    <= 11'd10;
         ratio_ff     <= 8'd2;
         enable_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         first_ff   <= first_in;
         bytes_ff   <= bytes_in;
         pend_ff    <= pend_in;
         restart_ff <= restart_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_MAX_BYTES: max_ff    <= csr_data;
               CSR_RETAIN:    retain_ff <= csr_data[10:0];
               CSR_RATIO:     ratio_ff  <= csr_data[7:0];
               CSR_ENABLE:    enable_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
         if (cmd.op == DP_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.op == DP_LATCH) begin
         req_ff <= req_data;
      end
      if (cmd.op == DP_CAP_HIT) begin
         cap_ff <= rd_entry;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/core/lec_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lec_ctrl
// Sequencer that steps each command through the datapath.
// ----------------------------------------------------------------------------
module lec_ctrl
   import lec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_ADD_LOOP, S_ADD_POP, S_RANGE_LOOP, S_RANGE_POP,
      S_CAP, S_TRIM_LOOP, S_TRIM_POP, S_TRUNC_LOOP, S_TRUNC_POP, S_RESP
   } state_type;

   state_type    state_ff, state_in;
   logic [2:0]   status_ff, status_in;
   rsp_kind_type kind_ff, kind_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      kind_in    = kind_ff;
      cmd.op     = DP_NOP;
      cmd.status = status_ff;
      cmd.kind   = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            kind_in   = RK_PLAIN;
            state_in  = S_RESP;
            case (stat.command)
               CMD_ADD: begin
                  if (stat.intr) begin
                     status_in = ST_INTR;
                  end else if (!stat.in_win) begin
                     state_in = S_ADD_LOOP;
                     if (stat.out_seq) begin
                        cmd.op   = DP_CLEAR;
                        cmd.kind = RK_PLAIN;
                     end
                  end
               end
               CMD_GET: begin
                  kind_in = RK_GET;
                  if (stat.empty) begin
                     status_in = ST_EMPTY;
                  end else if (stat.below) begin
                     cmd.op    = DP_CLEAR;
                     cmd.kind  = RK_PLAIN;
                     status_in = ST_SWAP;
                  end else if (stat.beyond) begin
                     status_in = ST_RANGE;
                     state_in  = S_RANGE_LOOP;
                  end else begin
                     cmd.op   = DP_RD_HIT;
                     kind_in  = RK_HIT;
                     state_in = S_CAP;
                  end
               end
               CMD_TRUNCATE: begin
                  if (stat.trunc_en) begin
                     if (stat.trunc_clear) begin
                        cmd.op   = DP_CLEAR;
                        cmd.kind = RK_PLAIN;
                     end else begin
                        state_in = S_TRUNC_LOOP;
                     end
                  end
               end
               CMD_RESET: begin
                  cmd.op   = DP_CLEAR;
                  cmd.kind = RK_RESET;
                  kind_in  = RK_RESET;
               end
               CMD_EXISTS: begin
                  kind_in = RK_EXISTS;
               end
               CMD_SET_REQ: begin
                  cmd.op = DP_SET_PEND;
               end
               CMD_CLEAR_REQ: begin
                  cmd.op = DP_CLR_PEND;
               end
               default: begin
               end
            endcase
         end
         S_ADD_LOOP: begin
            if (stat.over && stat.cnt_nz) begin
               if (stat.gt_pend) begin
                  status_in = ST_FULL;
                  state_in  = S_RESP;
               end else begin
                  cmd.op   = DP_RD_HEAD;
                  state_in = S_ADD_POP;
               end
            end else if (stat.ring_full) begin
               status_in = ST_FULL;
               state_in  = S_RESP;
            end else begin
               cmd.op   = DP_WRITE;
               state_in = S_RESP;
            end
         end
         S_ADD_POP: begin
            cmd.op   = DP_POP_FRONT;
            state_in = S_ADD_LOOP;
         end
         S_RANGE_LOOP: begin
            if (stat.trim_range) begin
               cmd.op   = DP_RD_HEAD;
               state_in = S_RANGE_POP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RANGE_POP: begin
            cmd.op   = DP_POP_FRONT;
            state_in = S_RANGE_LOOP;
         end
         S_CAP: begin
            cmd.op   = DP_CAP_HIT;
            state_in = S_TRIM_LOOP;
         end
         S_TRIM_LOOP: begin
            if (stat.trim_hit) begin
               cmd.op   = DP_RD_HEAD;
               state_in = S_TRIM_POP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_TRIM_POP: begin
            cmd.op   = DP_POP_FRONT;
            state_in = S_TRIM_LOOP;
         end
         S_TRUNC_LOOP: begin
            if (stat.trunc_more) begin
               cmd.op   = DP_RD_TAIL;
               state_in = S_TRUNC_POP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_TRUNC_POP: begin
            cmd.op   = DP_POP_BACK;
            state_in = S_TRUNC_LOOP;
         end
         S_RESP: begin
            if (!stat.out_busy) begin
               cmd.op   = DP_RESP;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
         kind_ff   <= RK_PLAIN;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         kind_ff   <= kind_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/windowed_log_entry_cache_core.sv -----
// Command flow: exists, request writes, reset, an interrupted or cached add, an empty or
// swapped-out get and a truncate that clears or does nothing go from decode to the result;
// other adds and truncates and an out-of-range get pass a loop state first; a get hit reads
// and captures its entry, then trims. Each front or back pop adds a RAM read of its length.
// The result is valid in the same cycle that the next command can enter; a waiting result
// stalls only the next result. Reset is synchronous and clears the window, not the RAM.
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_log_entry_cache_core
// FIFO cache of consecutive log entries keyed by index, with byte budget.
// ----------------------------------------------------------------------------
module windowed_log_entry_cache_core
   import lec_pkg::*;
#(
   parameter int CACHE_DEPTH = DEFAULT_CACHE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   lec_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   lec_datapath #(
      .CACHE_DEPTH(CACHE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
